// ===== rtl/core/idnps_pkg.sv =====
// ----------------------------------------------------------------------------
// idnps_pkg
// Shared types, character constants and helpers for the 3-2-4 number scanner.
// ----------------------------------------------------------------------------
package idnps_pkg;

   localparam int NUM_STATES  = 12;
   localparam int NUM_DIGITS  = 9;

   localparam int AREA_W      = 10;
   localparam int GROUP_W     = 7;
   localparam int SERIAL_W    = 14;
   localparam int SEP_W       = 2;
   localparam int FMT_W       = 2;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;

   localparam logic [SEP_W-1:0] SEP_NONE   = 2'd0;
   localparam logic [SEP_W-1:0] SEP_SPACE  = 2'd1;
   localparam logic [SEP_W-1:0] SEP_HYPHEN = 2'd2;
   localparam logic [SEP_W-1:0] SEP_PERIOD = 2'd3;

   localparam logic [FMT_W-1:0] FMT_PLAIN  = 2'd0;
   localparam logic [FMT_W-1:0] FMT_SAME   = 2'd1;
   localparam logic [FMT_W-1:0] FMT_MIXED  = 2'd2;

   typedef struct packed {
      logic [SEP_W-1:0]           sep2;
      logic [SEP_W-1:0]           sep1;
      logic [NUM_DIGITS-1:0][3:0] dig;
   } idnps_rec_type;

   typedef struct packed {
      logic [FMT_W-1:0]    format_class;
      logic [SEP_W-1:0]    second_separator;
      logic [SEP_W-1:0]    first_separator;
      logic [SERIAL_W-1:0] serial_number;
      logic [GROUP_W-1:0]  group_code;
      logic [AREA_W-1:0]   area_code;
   } idnps_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_0) && (c <= CHAR_9);
   endfunction

   function automatic logic is_boundary(input logic [7:0] c);
      return !is_digit(c) && !((c >= CHAR_LO_A) && (c <= CHAR_LO_Z))
             && !((c >= CHAR_UP_A) && (c <= CHAR_UP_Z));
   endfunction

   function automatic logic [SEP_W-1:0] sep_code(input logic [7:0] c);
      logic [SEP_W-1:0] code;
      case (c)
         CHAR_SPACE: code = SEP_SPACE;
         CHAR_DASH:  code = SEP_HYPHEN;
         CHAR_DOT:   code = SEP_PERIOD;
         default:    code = SEP_NONE;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/core/idnps_threads.sv =====
// ----------------------------------------------------------------------------
// idnps_threads
// Twelve partial-match threads; advances all of them on one byte per step.
// ----------------------------------------------------------------------------
module idnps_threads
   import idnps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    char_in,
   input  logic          restart,
   output logic          match,
   output idnps_rec_type match_rec
);

   logic [NUM_STATES-1:0] act_ff;
   logic [NUM_STATES-1:0] act_in;
   logic [NUM_STATES-1:0] cur_act;
   // state 0 always carries an all-zero record, so it has no storage
   idnps_rec_type         rec_ff [1:NUM_STATES-1];
   idnps_rec_type         rec_in [1:NUM_STATES-1];
   logic                  dig;
   logic                  sep;
   logic                  bnd;
   logic [3:0]            digit;
   logic [SEP_W-1:0]      code;

   assign cur_act   = restart ? NUM_STATES'(1) : act_ff;
   assign dig       = is_digit(char_in);
   assign code      = sep_code(char_in);
   assign sep       = (code != SEP_NONE);
   assign bnd       = is_boundary(char_in);
   assign digit     = char_in[3:0];
   assign match     = cur_act[NUM_STATES-1] && bnd;
   assign match_rec = rec_ff[NUM_STATES-1];

   always_comb begin
      act_in = '0;
      for (int k = 1; k < NUM_STATES; k++) begin
         rec_in[k] = '0;
      end
      if (dig) begin
         if (cur_act[0]) begin
            act_in[1]        = 1'b1;
            rec_in[1].dig[0] = digit;
         end
         if (cur_act[1]) begin
            act_in[2]        = 1'b1;
            rec_in[2]        = rec_ff[1];
            rec_in[2].dig[1] = digit;
         end
         if (cur_act[2]) begin
            act_in[3]        = 1'b1;
            rec_in[3]        = rec_ff[2];
            rec_in[3].dig[2] = digit;
         end
         if (cur_act[3]) begin
            act_in[5]        = 1'b1;
            rec_in[5]        = rec_ff[3];
            rec_in[5].dig[3] = digit;
         end else if (cur_act[4]) begin
            act_in[5]        = 1'b1;
            rec_in[5]        = rec_ff[4];
            rec_in[5].dig[3] = digit;
         end
         if (cur_act[5]) begin
            act_in[6]        = 1'b1;
            rec_in[6]        = rec_ff[5];
            rec_in[6].dig[4] = digit;
         end
         if (cur_act[6]) begin
            act_in[8]        = 1'b1;
            rec_in[8]        = rec_ff[6];
            rec_in[8].dig[5] = digit;
         end else if (cur_act[7]) begin
            act_in[8]        = 1'b1;
            rec_in[8]        = rec_ff[7];
            rec_in[8].dig[5] = digit;
         end
         if (cur_act[8]) begin
            act_in[9]        = 1'b1;
            rec_in[9]        = rec_ff[8];
            rec_in[9].dig[6] = digit;
         end
         if (cur_act[9]) begin
            act_in[10]         = 1'b1;
            rec_in[10]         = rec_ff[9];
            rec_in[10].dig[7]  = digit;
         end
         if (cur_act[10]) begin
            act_in[11]         = 1'b1;
            rec_in[11]         = rec_ff[10];
            rec_in[11].dig[8]  = digit;
         end
      end else if (sep) begin
         if (cur_act[6]) begin
            act_in[7]      = 1'b1;
            rec_in[7]      = rec_ff[6];
            rec_in[7].sep2 = code;
         end
         if (cur_act[3]) begin
            act_in[4]      = 1'b1;
            rec_in[4]      = rec_ff[3];
            rec_in[4].sep1 = code;
         end
      end
      if (bnd) begin
         act_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= NUM_STATES'(1);
      end else if (step) begin
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int k = 1; k < NUM_STATES; k++) begin
            rec_ff[k] <= rec_in[k];
         end
      end
   end

endmodule

// ===== rtl/core/idnps_format.sv =====
// ----------------------------------------------------------------------------
// idnps_format
// Converts a completed match record to binary groups and a format class.
// ----------------------------------------------------------------------------
module idnps_format
   import idnps_pkg::*;
(
   input  idnps_rec_type    rec,
   output idnps_result_type result
);

   logic [AREA_W-1:0]   area;
   logic [GROUP_W-1:0]  grp;
   logic [SERIAL_W-1:0] ser;
   logic [FMT_W-1:0]    fmt;

   assign area = AREA_W'(rec.dig[0]) * AREA_W'(100)
               + AREA_W'(rec.dig[1]) * AREA_W'(10)
               + AREA_W'(rec.dig[2]);
   assign grp  = GROUP_W'(rec.dig[3]) * GROUP_W'(10)
               + GROUP_W'(rec.dig[4]);
   assign ser  = SERIAL_W'(rec.dig[5]) * SERIAL_W'(1000)
               + SERIAL_W'(rec.dig[6]) * SERIAL_W'(100)
               + SERIAL_W'(rec.dig[7]) * SERIAL_W'(10)
               + SERIAL_W'(rec.dig[8]);

   always_comb begin
      if ((rec.sep1 == SEP_NONE) && (rec.sep2 == SEP_NONE)) begin
         fmt = FMT_PLAIN;
      end else if ((rec.sep1 != SEP_NONE) && (rec.sep1 == rec.sep2)) begin
         fmt = FMT_SAME;
      end else begin
         fmt = FMT_MIXED;
      end
   end

   assign result.area_code        = area;
   assign result.group_code       = grp;
   assign result.serial_number    = ser;
   assign result.first_separator  = rec.sep1;
   assign result.second_separator = rec.sep2;
   assign result.format_class     = fmt;

endmodule

// ===== rtl/core/id_number_pattern_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// id_number_pattern_scanner_unit
// Scans a byte stream for 3-2-4 nine-digit numbers and reports each match.
// A match passes from the input register to the result register.
// Throughput: one byte per cycle unless a match waits on a full result
// register; the thread update is one step of logic between the two registers.
// Reset: synchronous; clears both valid flags and puts the matcher in its
// start state (stream start counts as a boundary).
// ----------------------------------------------------------------------------
module id_number_pattern_scanner_unit
   import idnps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] input_byte
   input  logic [0:0]  req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // area_code, group_code, serial_number,
                                    // first_separator, second_separator,
                                    // format_class, zero fill
);

   localparam int RES_W = $bits(idnps_result_type);

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_restart_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   idnps_result_type out_data_ff;
   logic             match;
   logic             step;
   idnps_rec_type    match_rec;
   idnps_result_type result;

   assign step       = in_valid_ff && (!match || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   idnps_threads u_threads (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_in   (in_byte_ff),
      .restart   (in_restart_ff),
      .match     (match),
      .match_rec (match_rec)
   );

   idnps_format u_format (
      .rec    (match_rec),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (step && match) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff    <= req_tdata;
         in_restart_ff <= req_tuser[0];
      end
      if (step && match) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(40 - RES_W)'(0), out_data_ff};

endmodule
